### hdl/ebs_pkg.sv
// Shared constants, types and helper functions for the 3x3 edge-aware box smoother.
// Used by every module of the block; no dependencies.

package ebs_pkg;

  localparam int MAX_SIDE    = 16;
  localparam int PIX_W       = 8;
  localparam int SIDE_W      = 5;
  localparam int COORD_W     = 4;
  localparam int SUM_W       = 12;
  localparam int MEM_DEPTH   = 3 * MAX_SIDE;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int MAX_RESULTS = MAX_SIDE + 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 2);
  localparam int RECIP_SHIFT = 15;
  localparam int RECIP_W     = 14;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int RECIP4 = (2 ** RECIP_SHIFT) / 4;
  localparam int RECIP6 = (2 ** RECIP_SHIFT + 5) / 6;
  localparam int RECIP9 = (2 ** RECIP_SHIFT + 8) / 9;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(8);

  typedef enum logic [1:0] {
    DIV4,
    DIV6,
    DIV9
  } div_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_HOLD,
    ST_READ,
    ST_DRAIN,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic busy;
    logic held_valid;
  } ctrl_status_t;

  function automatic logic [1:0] mod3(input logic [SIDE_W-1:0] v);
    logic [2:0] t;
    logic [1:0] r;
    r = '0;
    for (int i = SIDE_W - 1; i >= 0; i--) begin
      t = {r, v[i]};
      if (t >= 3'd3) begin
        r = 2'(t - 3'd3);
      end else begin
        r = t[1:0];
      end
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [1:0] slot,
                                                input logic [COORD_W-1:0] col);
    return ADDR_W'(slot) * ADDR_W'(MAX_SIDE) + ADDR_W'(col);
  endfunction

  function automatic logic [RECIP_W-1:0] recip(input div_t d);
    logic [RECIP_W-1:0] r;
    case (d)
      DIV4:    r = RECIP_W'(RECIP4);
      DIV6:    r = RECIP_W'(RECIP6);
      DIV9:    r = RECIP_W'(RECIP9);
      default: r = RECIP_W'(RECIP9);
    endcase
    return r;
  endfunction

endpackage

### hdl/ebs_line_store.sv
// Three-row line store: one write port, one read port with registered data.
// Depends on ebs_pkg.

module ebs_line_store
  import ebs_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [MEM_DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/ebs_mean_div.sv
// Window sum divided by 4, 6 or 9 through a reciprocal multiply, result registered.
// Depends on ebs_pkg.

module ebs_mean_div
  import ebs_pkg::*;
(
  input  logic             clk,
  input  logic             start,
  input  logic [SUM_W-1:0] sum,
  input  div_t             div,
  output logic [PIX_W-1:0] mean
);

  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  mean_r;

  assign prod = PROD_W'(sum) * PROD_W'(recip(div));

  always_ff @(posedge clk) begin
    if (start) begin
      mean_r <= prod[RECIP_SHIFT +: PIX_W];
    end
  end

  assign mean = mean_r;

endmodule

### hdl/ebs_ctrl.sv
// Sequencer: position counters, window tap walk and accumulation, held result,
// output register. Depends on ebs_pkg; drives ebs_line_store and ebs_mean_div.

module ebs_ctrl
  import ebs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [SIDE_W-1:0]  cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PIX_W-1:0]   in_pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_smoothed,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic               out_last_of_run,
  output logic               out_end_of_frame,
  output mem_req_t           mem_req,
  input  logic [PIX_W-1:0]   mem_rdata,
  output logic               div_start,
  output logic [SUM_W-1:0]   div_sum,
  output div_t               div_sel,
  input  logic [PIX_W-1:0]   div_mean,
  output ctrl_status_t       status
);

  state_t state_r, state_nxt;

  logic [SIDE_W-1:0]  side_r;
  logic [COORD_W-1:0] ir_r, ic_r;
  logic [SIDE_W-1:0]  er_r;
  logic [COORD_W-1:0] ec_r;
  logic [CNT_W-1:0]   k_r;
  logic [1:0]         dr_r, dc_r;
  logic               tap_vld_r;
  logic [SUM_W-1:0]   sum_r;
  logic               hold_mode_r;
  logic               held_valid_r;
  logic [PIX_W-1:0]   held_val_r;
  logic [COORD_W-1:0] held_row_r, held_col_r;

  logic               out_valid_r;
  logic [PIX_W-1:0]   out_smoothed_r;
  logic [COORD_W-1:0] out_row_r, out_col_r;
  logic               out_last_r, out_eof_r;

  logic [SIDE_W-1:0]  n, n_m1;
  logic [SIDE_W-1:0]  ec_inc, er_nx, rr, cc;
  logic [COORD_W-1:0] ec_nx;
  logic [CNT_W-1:0]   k_inc;
  logic               cond_cur, cond_nx, final_px, out_free, row_ok, col_ok;
  logic               in_acc;
  logic               out_load;

  function automatic logic released(input logic [SIDE_W-1:0] r,
                                    input logic [COORD_W-1:0] c,
                                    input logic [COORD_W-1:0] ir,
                                    input logic [COORD_W-1:0] ic,
                                    input logic [SIDE_W-1:0] nn);
    logic [SIDE_W-1:0] nr, nc;
    nr = (r + SIDE_W'(1) < nn) ? r + SIDE_W'(1) : nn - SIDE_W'(1);
    nc = (SIDE_W'(c) + SIDE_W'(1) < nn) ? SIDE_W'(c) + SIDE_W'(1) : nn - SIDE_W'(1);
    return (nr < SIDE_W'(ir)) || ((nr == SIDE_W'(ir)) && (nc <= SIDE_W'(ic)));
  endfunction

  always_comb begin
    if (side_r < SIDE_W'(2)) begin
      n = SIDE_W'(2);
    end else if (side_r > SIDE_W'(MAX_SIDE)) begin
      n = SIDE_W'(MAX_SIDE);
    end else begin
      n = side_r;
    end
  end

  assign n_m1     = n - SIDE_W'(1);
  assign final_px = (SIDE_W'(ir_r) == n_m1) && (SIDE_W'(ic_r) == n_m1);
  assign k_inc    = k_r + CNT_W'(1);
  assign ec_inc   = SIDE_W'(ec_r) + SIDE_W'(1);
  assign ec_nx    = (ec_inc == n) ? '0 : ec_inc[COORD_W-1:0];
  assign er_nx    = (ec_inc == n) ? er_r + SIDE_W'(1) : er_r;

  assign cond_cur = (er_r < n) && (k_r < CNT_W'(MAX_RESULTS)) &&
                    released(er_r, ec_r, ir_r, ic_r, n);
  assign cond_nx  = (er_nx < n) && (k_inc < CNT_W'(MAX_RESULTS)) &&
                    released(er_nx, ec_nx, ir_r, ic_r, n);

  assign rr     = er_r + SIDE_W'(dr_r) - SIDE_W'(1);
  assign cc     = SIDE_W'(ec_r) + SIDE_W'(dc_r) - SIDE_W'(1);
  assign row_ok = !((er_r == '0) && (dr_r == 2'd0)) && !((er_r == n_m1) && (dr_r == 2'd2));
  assign col_ok = !((ec_r == '0) && (dc_r == 2'd0)) &&
                  !((SIDE_W'(ec_r) == n_m1) && (dc_r == 2'd2));

  assign out_free = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign out_load = out_free &&
                    ((state_r == ST_HOLD) || ((state_r == ST_LOAD) && !hold_mode_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (held_valid_r) begin
          state_nxt = ST_HOLD;
        end else if (cond_cur || (final_px && (er_r < n))) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (out_free) state_nxt = ST_CHECK;
      end
      ST_READ: begin
        if ((dr_r == 2'd2) && (dc_r == 2'd2)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (hold_mode_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          state_nxt = ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    mem_req.we    = in_valid && (state_r == ST_IDLE);
    mem_req.waddr = addr_of(mod3(SIDE_W'(ir_r)), ic_r);
    mem_req.wdata = in_pixel;
    mem_req.re    = (state_r == ST_READ) && row_ok && col_ok;
    mem_req.raddr = addr_of(mod3(rr), cc[COORD_W-1:0]);
    div_start     = (state_r == ST_DIV);
    div_sum       = sum_r;
    case ({(er_r == '0) || (er_r == n_m1), (ec_r == '0) || (SIDE_W'(ec_r) == n_m1)})
      2'b11:   div_sel = DIV4;
      2'b10:   div_sel = DIV6;
      2'b01:   div_sel = DIV6;
      default: div_sel = DIV9;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      side_r       <= SIDE_RESET;
      ir_r         <= '0;
      ic_r         <= '0;
      er_r         <= '0;
      ec_r         <= '0;
      k_r          <= '0;
      dr_r         <= '0;
      dc_r         <= '0;
      tap_vld_r    <= 1'b0;
      hold_mode_r  <= 1'b0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        // frame restart on a side write
        side_r       <= cfg_wdata;
        ir_r         <= '0;
        ic_r         <= '0;
        er_r         <= '0;
        ec_r         <= '0;
        k_r          <= '0;
        held_valid_r <= 1'b0;
      end else begin
        case (state_r)
          ST_CHECK: begin
            if (!held_valid_r) begin
              if (cond_cur || (final_px && (er_r < n))) begin
                dr_r        <= '0;
                dc_r        <= '0;
                sum_r       <= '0;
                tap_vld_r   <= 1'b0;
                hold_mode_r <= !cond_cur;
              end else begin
                k_r <= '0;
                if (final_px) begin
                  ir_r <= '0;
                  ic_r <= '0;
                  er_r <= '0;
                  ec_r <= '0;
                end else if (SIDE_W'(ic_r) == n_m1) begin
                  ic_r <= '0;
                  ir_r <= ir_r + COORD_W'(1);
                end else begin
                  ic_r <= ic_r + COORD_W'(1);
                end
              end
            end
          end
          ST_HOLD: begin
            if (out_free) begin
              out_smoothed_r   <= held_val_r;
              out_row_r        <= held_row_r;
              out_col_r        <= held_col_r;
              out_last_r       <= !cond_cur;
              out_eof_r        <= (SIDE_W'(held_row_r) == n_m1) &&
                                  (SIDE_W'(held_col_r) == n_m1);
              held_valid_r     <= 1'b0;
              k_r              <= k_inc;
            end
          end
          ST_READ: begin
            if (tap_vld_r) sum_r <= sum_r + SUM_W'(mem_rdata);
            tap_vld_r <= mem_req.re;
            if (dc_r == 2'd2) begin
              dc_r <= '0;
              dr_r <= dr_r + 2'd1;
            end else begin
              dc_r <= dc_r + 2'd1;
            end
          end
          ST_DRAIN: begin
            if (tap_vld_r) sum_r <= sum_r + SUM_W'(mem_rdata);
            tap_vld_r <= 1'b0;
          end
          ST_LOAD: begin
            if (hold_mode_r) begin
              held_valid_r <= 1'b1;
              held_val_r   <= div_mean;
              held_row_r   <= er_r[COORD_W-1:0];
              held_col_r   <= ec_r;
              k_r          <= '0;
              ir_r         <= '0;
              ic_r         <= '0;
              er_r         <= '0;
              ec_r         <= '0;
            end else if (out_free) begin
              out_smoothed_r <= div_mean;
              out_row_r      <= er_r[COORD_W-1:0];
              out_col_r      <= ec_r;
              out_last_r     <= !cond_nx;
              out_eof_r      <= (er_r == n_m1) && (SIDE_W'(ec_r) == n_m1);
              k_r            <= k_inc;
              er_r           <= er_nx;
              ec_r           <= ec_nx;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_smoothed     = out_smoothed_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_last_of_run  = out_last_r;
  assign out_end_of_frame = out_eof_r;

  assign status.busy       = (state_r != ST_IDLE) || in_acc;
  assign status.held_valid = held_valid_r;

endmodule

### hdl/edge_aware_box_smoothing_3x3.sv
// 3x3 box smoother with shrinking border windows over a square 8-bit image.
// Top level; depends on ebs_pkg, ebs_line_store, ebs_mean_div and ebs_ctrl.
//
// Usage:
//   Pixels enter row-major on in_valid/in_ready, one per transaction. Each
//   pixel releases zero or more results on out_valid/out_ready in row-major
//   order; out_last_of_run marks the last result of a pixel, out_end_of_frame
//   the bottom-right position. The final pixel of a frame flushes the rest.
//   cfg_we/cfg_wdata set the side length (2..16, clipped) and restart the frame.
//   Sequence: a pixel that releases nothing passes only the check; each result
//   adds a check, nine tap reads, a drain, a divide and a load, with one tap
//   read at a time through the single read port of the line store. At side 16
//   the bottom-right result is held and delivered with the first pixel of the
//   next frame.
//   Reset: side returns to 8, position counters and held result clear. The
//   line store is not cleared; a window only reads pixels of the current frame.
//   Stall: a result waits in the output register; work continues up to the
//   next result, and a new pixel is taken while the last result still waits.

module edge_aware_box_smoothing_3x3
  import ebs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [SIDE_W-1:0]  cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PIX_W-1:0]   in_pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_smoothed,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic               out_last_of_run,
  output logic               out_end_of_frame
);

  mem_req_t         mem_req;
  logic [PIX_W-1:0] mem_rdata;
  logic             div_start;
  logic [SUM_W-1:0] div_sum;
  div_t             div_sel;
  logic [PIX_W-1:0] div_mean;
  ctrl_status_t     status;

  ebs_line_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  ebs_mean_div u_div (
    .clk   (clk),
    .start (div_start),
    .sum   (div_sum),
    .div   (div_sel),
    .mean  (div_mean)
  );

  ebs_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_smoothed     (out_smoothed),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame),
    .mem_req          (mem_req),
    .mem_rdata        (mem_rdata),
    .div_start        (div_start),
    .div_sum          (div_sum),
    .div_sel          (div_sel),
    .div_mean         (div_mean),
    .status           (status)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (status.busy && !in_ready))
    else $error("no step started after input transaction");

  a_eof_diag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_frame) |-> (out_row == out_col))
    else $error("end of frame off the bottom-right position");

  a_cfg_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !status.held_valid)
    else $error("held result survived a side write");

endmodule

### dv/tb_edge_aware_box_smoothing_3x3.sv
// Self-checking testbench for the 3x3 edge-aware box smoother: random and directed
// pixel frames with valid/ready stalls, checked against an in-bench line-buffer predictor.
// Depends on ebs_pkg and edge_aware_box_smoothing_3x3.
`timescale 1ns / 100ps

module tb_edge_aware_box_smoothing_3x3;
  import ebs_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 410;
  localparam int HOLD_START = 60;
  localparam int BIG_START = 100;
  localparam int BLOCK_MAX = 64;

  typedef struct packed {
    logic [PIX_W-1:0]   smoothed;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
    logic               eof;
  } smooth_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [SIDE_W-1:0]  cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PIX_W-1:0]   in_pixel = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PIX_W-1:0]   out_smoothed;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               out_last_of_run;
  logic               out_end_of_frame;

  edge_aware_box_smoothing_3x3 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_smoothed     (out_smoothed),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state
  logic [PIX_W-1:0]  line_mem [0:MEM_DEPTH-1];
  logic [SIDE_W-1:0] side_reg;
  int                cur_row, cur_col, next_emit;
  bit                held_v;
  int                held_val, held_r, held_c;

  logic [PIX_W-1:0] pending_pixels[$];
  smooth_res_t      expected_results[$];

  int  issued = 0;
  int  accepted = 0;
  int  results_seen = 0;
  int  side_writes = 0;
  int  errors = 0;
  bit  in_taken = 1'b0;
  bit  calm = 1'b0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  hold_req = 0;
  int  hold_done = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  function automatic int eff_side();
    if (side_reg < 2) return 2;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return int'(side_reg);
  endfunction

  function automatic int window_avg(input int r, input int c, input int n);
    int sum, cnt, rr, cc;
    sum = 0;
    cnt = 0;
    for (rr = r - 1; rr <= r + 1; rr++) begin
      for (cc = c - 1; cc <= c + 1; cc++) begin
        if (rr >= 0 && rr < n && cc >= 0 && cc < n) begin
          sum += int'(line_mem[(rr % 3) * MAX_SIDE + cc]);
          cnt++;
        end
      end
    end
    return sum / cnt;
  endfunction

  function automatic smooth_res_t make_res(input int v, input int r, input int c, input int n);
    smooth_res_t res;
    res.smoothed = PIX_W'(v);
    res.row = COORD_W'(r);
    res.col = COORD_W'(c);
    res.last = 1'b0;
    res.eof = (r == n - 1 && c == n - 1);
    return res;
  endfunction

  function automatic void pred_reset();
    side_reg = SIDE_RESET;
    cur_row = 0;
    cur_col = 0;
    next_emit = 0;
    held_v = 1'b0;
  endfunction

  function automatic void pred_config(input logic [SIDE_W-1:0] v);
    side_reg = v;
    cur_row = 0;
    cur_col = 0;
    next_emit = 0;
    held_v = 1'b0;
  endfunction

  function automatic void smooth_step(input logic [PIX_W-1:0] pix);
    smooth_res_t batch[$];
    int n, total, arrived, r, c, nr, nc;
    bit blocked;
    n = eff_side();
    total = n * n;
    if (held_v) begin
      batch.push_back(make_res(held_val, held_r, held_c, n));
      held_v = 1'b0;
    end
    if (cur_row >= n || cur_col >= n) begin
      cur_row = 0;
      cur_col = 0;
      next_emit = 0;
    end
    line_mem[(cur_row % 3) * MAX_SIDE + cur_col] = pix;
    arrived = cur_row * n + cur_col;
    blocked = 1'b0;
    while (!blocked && next_emit < total && batch.size() < MAX_RESULTS) begin
      r = next_emit / n;
      c = next_emit % n;
      nr = (r + 1 < n) ? r + 1 : n - 1;
      nc = (c + 1 < n) ? c + 1 : n - 1;
      if (nr * n + nc > arrived) begin
        blocked = 1'b1;
      end else begin
        batch.push_back(make_res(window_avg(r, c, n), r, c, n));
        next_emit++;
      end
    end
    if (arrived == total - 1) begin
      // frame end; a result that did not fit is held for the next pixel
      if (next_emit < total) begin
        held_r = next_emit / n;
        held_c = next_emit % n;
        held_val = window_avg(held_r, held_c, n);
        held_v = 1'b1;
      end
      cur_row = 0;
      cur_col = 0;
      next_emit = 0;
    end else begin
      cur_col++;
      if (cur_col >= n) begin
        cur_col = 0;
        cur_row++;
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_results.push_back(batch[i]);
  endfunction

  function automatic int draw_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 24) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Predictor and monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      pred_reset();
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: row %0d col %0d smoothed %0d",
                 out_row, out_col, out_smoothed);
          errors++;
        end else begin
          smooth_res_t want;
          want = expected_results.pop_front();
          check_field("smoothed", want.smoothed, out_smoothed);
          check_field("out_row", want.row, out_row);
          check_field("out_col", want.col, out_col);
          check_field("last_of_run", want.last, out_last_of_run);
          check_field("end_of_frame", want.eof, out_end_of_frame);
        end
      end
      if (cfg_we) pred_config(cfg_wdata);
      if (in_valid && in_ready) begin
        smooth_step(in_pixel);
        accepted++;
      end
    end
  end

  // Pixel driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        in_valid <= 1'b1;
        in_pixel <= pending_pixels.pop_front();
        tx_gap <= draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off
  always @(negedge clk) begin
    if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      out_ready <= 1'b1;
      rx_gap <= draw_gap();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_results.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_one(input logic [PIX_W-1:0] v);
    pending_pixels.push_back(v);
    issued++;
  endtask

  task automatic push_pixels(input int count);
    @(posedge clk);
    repeat (count) push_one(rand_pixel());
  endtask

  task automatic wait_drain();
    while (accepted != issued || expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_side(input logic [SIDE_W-1:0] v);
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    side_writes++;
    @(posedge clk);
  endtask

  function automatic logic [SIDE_W-1:0] pick_side();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return SIDE_W'($urandom_range(0, 1));
    if (r < 12) return SIDE_W'($urandom_range(17, 31));
    if (r < 20) return SIDE_W'($urandom_range(9, 15));
    return SIDE_W'($urandom_range(2, 8));
  endfunction

  initial begin
    int n, cnt;
    logic [SIDE_W-1:0] s;
    bit hold_done_once, big_done;
    hold_done_once = 1'b0;
    big_done = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Reset side of 8: ten pixels release the top-left corner, then a restart
    @(posedge clk);
    for (int i = 0; i < 10; i++) push_one((i % 2 == 0) ? 8'hff : 8'h00);
    // Side below range acts as 2: full-scale corners
    write_side('0);
    @(posedge clk);
    repeat (4) push_one(8'hff);
    // Side 3: corners, edges and the interior window
    write_side(SIDE_W'(3));
    @(posedge clk);
    push_one(8'h00); push_one(8'hff); push_one(8'h00);
    push_one(8'hff); push_one(8'hff); push_one(8'hff);
    push_one(8'h00); push_one(8'hff); push_one(8'h01);

    while (issued < RANDOM_ITEMS) begin
      if (!hold_done_once && issued >= HOLD_START) begin
        // receiver stalls long while pixels keep coming, then the sender waits for all results
        hold_done_once = 1'b1;
        write_side(SIDE_W'(8));
        calm = 1'b0;
        @(posedge clk);
        hold_req++;
        push_pixels(24);
        wait_drain();
        push_pixels(16);
      end else if (!big_done && issued >= BIG_START) begin
        // full side: bottom-right result is held and delivered with the next pixel
        big_done = 1'b1;
        write_side(SIDE_W'(MAX_SIDE));
        calm = $urandom_range(0, 1);
        push_pixels(MAX_SIDE * MAX_SIDE + 1);
      end else begin
        s = pick_side();
        write_side(s);
        n = (s < 2) ? 2 : ((s > MAX_SIDE) ? MAX_SIDE : int'(s));
        calm = ($urandom_range(0, 3) == 0);
        if (n <= 8) begin
          cnt = n * n * $urandom_range(1, 3);
          if ($urandom_range(0, 9) < 3) cnt += $urandom_range(1, n * n - 1);
        end else begin
          cnt = $urandom_range(1, 4 * n);
        end
        if (cnt > BLOCK_MAX) cnt = BLOCK_MAX;
        if (big_done && cnt > RANDOM_ITEMS - issued) cnt = RANDOM_ITEMS - issued;
        push_pixels(cnt);
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d pixels, %0d smoothed results, %0d side writes (clipped sides,",
             accepted, results_seen, side_writes);
    $display("mid-frame restarts, long output stall, held corner at full side).");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
